### src/ebad_pkg.sv
// ============================================================================
// ebad_pkg: shared types and constants of the elevation box-average decimator
// Field widths, configuration codes, reset values, queue sizing and the
// state encodings of the geometry and divider sequencers.
// ============================================================================
`default_nettype none

package ebad_pkg;

  // Storage sizing
  localparam int MAX_WIDTH = 4096;
  localparam int MAX_BLOCK = 16;

  // Fixed field widths
  localparam int GW_W       = 13;  // grid_width register
  localparam int BS_W       = 5;   // block_size register
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 24;
  localparam int MEAN_W     = 24;
  localparam int FRAC_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Derived widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int BLK_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int NSQ_W  = 2 * $clog2(MAX_BLOCK) + 1;
  localparam int DVD_W  = SUM_W + FRAC_W;
  localparam int GCNT_W = $clog2(GW_W);

  // Mean divider: quotient bits retired per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = DVD_W / DIV_BITS;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Register reset values
  localparam int GRID_WIDTH_RST = 4096;
  localparam int BLOCK_SIZE_RST = 1;
  localparam int NBLK_RST       = GRID_WIDTH_RST / BLOCK_SIZE_RST;
  localparam int LIMIT_RST      = NBLK_RST * BLOCK_SIZE_RST;

  typedef logic [GW_W-1:0]                width_t;
  typedef logic [BS_W-1:0]                bsize_t;
  typedef logic [COL_W-1:0]               col_t;
  typedef logic [BLK_W-1:0]               bcnt_t;
  typedef logic signed [SAMPLE_W-1:0]     sample_t;
  typedef logic signed [SUM_W-1:0]        sum_t;
  typedef logic signed [MEAN_W-1:0]       mean_t;
  typedef logic [NSQ_W-1:0]               nsq_t;
  typedef logic [NSQ_W:0]                 trial_t;
  typedef logic [DVD_W-1:0]               dvd_t;
  typedef logic [SUM_W-1:0]               mag_t;
  typedef logic [DCNT_W-1:0]              dcnt_t;
  typedef logic [GCNT_W-1:0]              gcnt_t;
  typedef logic [BS_W:0]                  gtrial_t;
  typedef logic [QPTR_W-1:0]              qptr_t;
  typedef logic [QCNT_W-1:0]              qcnt_t;
  typedef logic [CFG_IDX_W-1:0]           cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]          cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH = 2'd0,
    CFG_BLOCK_SIZE = 2'd1,
    CFG_NODATA     = 2'd2,
    CFG_SEA        = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    sample_t sample;
    logic    frame_end;
  } in_item_t;

  typedef struct packed {
    mean_t block_mean;
    logic  row_end;
  } out_item_t;

  // Effective (clamped) configuration
  typedef struct packed {
    width_t  width;
    bsize_t  block;
    sample_t nodata;
    sample_t sea;
  } cfg_t;

  // Row geometry: blocks per row and number of columns covered by them
  typedef struct packed {
    width_t nblk;
    width_t limit;
    logic   busy;
  } geo_t;

  // Finished block sum waiting for the divider
  typedef struct packed {
    sum_t sum;
    logic row_end;
  } blk_entry_t;

  typedef enum logic [1:0] {
    GEO_IDLE,
    GEO_DIV,
    GEO_MUL
  } geo_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

### src/ebad_ram.sv
// ============================================================================
// ebad_ram: generic simple dual-port RAM
// One write port, one read port with registered read data (old data on a
// read of the address being written).
// ============================================================================
`default_nettype none

module ebad_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/ebad_geom.sv
// ============================================================================
// ebad_geom: row geometry sequencer
// Works out blocks per row (width / block) with a bit-serial divider and the
// number of columns those blocks cover, after every configuration write.
// ============================================================================
`default_nettype none

module ebad_geom (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  ebad_pkg::cfg_t  cfg,
  output ebad_pkg::geo_t  geo
);

  ebad_pkg::geo_state_t state_r, state_nxt;
  ebad_pkg::gcnt_t      cnt_r, cnt_nxt;
  ebad_pkg::width_t     dvd_r, dvd_nxt;
  ebad_pkg::bsize_t     rem_r, rem_nxt;
  ebad_pkg::width_t     nblk_r, nblk_nxt;
  ebad_pkg::width_t     limit_r, limit_nxt;
  ebad_pkg::gtrial_t    trial;
  logic                 ge;
  logic                 do_load, do_step, do_mul;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ebad_pkg::GEO_IDLE: state_nxt = ebad_pkg::GEO_IDLE;
      ebad_pkg::GEO_DIV: begin
        if (cnt_r == ebad_pkg::gcnt_t'(ebad_pkg::GW_W - 1)) begin
          state_nxt = ebad_pkg::GEO_MUL;
        end
      end
      ebad_pkg::GEO_MUL:  state_nxt = ebad_pkg::GEO_IDLE;
      default:            state_nxt = ebad_pkg::GEO_IDLE;
    endcase
    if (start) begin
      state_nxt = ebad_pkg::GEO_DIV;
    end
  end

  // Outputs
  always_comb begin
    do_load = start;
    do_step = 1'b0;
    do_mul  = 1'b0;
    case (state_r)
      ebad_pkg::GEO_IDLE: ;
      ebad_pkg::GEO_DIV:  do_step = !start;
      ebad_pkg::GEO_MUL:  do_mul  = !start;
      default:            ;
    endcase
  end

  // Restoring division step, one quotient bit per cycle
  assign trial = {rem_r, dvd_r[ebad_pkg::GW_W-1]};
  assign ge    = (trial >= {1'b0, cfg.block});

  always_comb begin
    cnt_nxt   = cnt_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    nblk_nxt  = nblk_r;
    limit_nxt = limit_r;
    if (do_load) begin
      cnt_nxt = '0;
      dvd_nxt = cfg.width;
      rem_nxt = '0;
    end else if (do_step) begin
      cnt_nxt = cnt_r + ebad_pkg::gcnt_t'(1);
      dvd_nxt = {dvd_r[ebad_pkg::GW_W-2:0], ge};
      rem_nxt = ge ? ebad_pkg::bsize_t'(trial - {1'b0, cfg.block})
                   : ebad_pkg::bsize_t'(trial);
    end else if (do_mul) begin
      nblk_nxt  = dvd_r;
      limit_nxt = ebad_pkg::width_t'(dvd_r * cfg.block);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ebad_pkg::GEO_IDLE;
      cnt_r   <= '0;
      nblk_r  <= ebad_pkg::width_t'(ebad_pkg::NBLK_RST);
      limit_r <= ebad_pkg::width_t'(ebad_pkg::LIMIT_RST);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      nblk_r  <= nblk_nxt;
      limit_r <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign geo.nblk  = nblk_r;
  assign geo.limit = limit_r;
  assign geo.busy  = (state_r != ebad_pkg::GEO_IDLE);

endmodule

`default_nettype wire

### src/ebad_front.sv
// ============================================================================
// ebad_front: sample classifier and column accumulator
// Tracks raster position, substitutes missing samples, and sums each block
// column into the accumulator row; finished block sums go to the queue.
// ============================================================================
`default_nettype none

module ebad_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  ebad_pkg::in_item_t   in_data,
  input  ebad_pkg::cfg_t       cfg,
  input  ebad_pkg::geo_t       geo,
  output logic                 q_push,
  output ebad_pkg::blk_entry_t q_entry
);

  // Raster position
  ebad_pkg::col_t  col_cnt_r, col_cnt_nxt;
  ebad_pkg::bcnt_t cib_r, cib_nxt;
  ebad_pkg::bcnt_t rib_r, rib_nxt;
  ebad_pkg::col_t  bcol_r, bcol_nxt;

  logic             in_blk, first, blk_end, band_end, row_done, last_blk;
  ebad_pkg::sample_t v;

  // Accumulate stage
  logic              s1_valid_r, s1_first_r, s1_emit_r, s1_row_end_r;
  ebad_pkg::col_t    s1_idx_r;
  ebad_pkg::sample_t s1_v_r;

  // Most recent accumulator write, for read-after-write forwarding
  logic              last_valid_r;
  ebad_pkg::col_t    last_idx_r;
  ebad_pkg::sum_t    last_sum_r;

  logic [ebad_pkg::SUM_W-1:0] ram_q;
  ebad_pkg::sum_t             base, sum;

  // Classify
  assign in_blk   = (ebad_pkg::width_t'(col_cnt_r) < geo.limit);
  assign first    = (rib_r == '0) && (cib_r == '0);
  assign blk_end  = (ebad_pkg::bsize_t'(cib_r) + ebad_pkg::bsize_t'(1) >= cfg.block);
  assign band_end = (ebad_pkg::bsize_t'(rib_r) + ebad_pkg::bsize_t'(1) >= cfg.block);
  assign row_done = (ebad_pkg::width_t'(col_cnt_r) + ebad_pkg::width_t'(1) >= cfg.width);
  assign last_blk = (ebad_pkg::width_t'(bcol_r) + ebad_pkg::width_t'(1) >= geo.nblk);
  assign v        = (in_data.sample == cfg.nodata) ? cfg.sea : in_data.sample;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    cib_nxt     = cib_r;
    rib_nxt     = rib_r;
    bcol_nxt    = bcol_r;
    if (accept) begin
      if (in_blk) begin
        if (blk_end) begin
          cib_nxt  = '0;
          bcol_nxt = bcol_r + ebad_pkg::col_t'(1);
        end else begin
          cib_nxt = cib_r + ebad_pkg::bcnt_t'(1);
        end
      end
      if (row_done) begin
        col_cnt_nxt = '0;
        cib_nxt     = '0;
        bcol_nxt    = '0;
        rib_nxt     = band_end ? '0 : rib_r + ebad_pkg::bcnt_t'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + ebad_pkg::col_t'(1);
      end
      if (in_data.frame_end) begin
        col_cnt_nxt = '0;
        cib_nxt     = '0;
        rib_nxt     = '0;
        bcol_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r    <= '0;
      cib_r        <= '0;
      rib_r        <= '0;
      bcol_r       <= '0;
      s1_valid_r   <= 1'b0;
      last_valid_r <= 1'b0;
    end else begin
      col_cnt_r  <= col_cnt_nxt;
      cib_r      <= cib_nxt;
      rib_r      <= rib_nxt;
      bcol_r     <= bcol_nxt;
      s1_valid_r <= accept && in_blk;
      if (s1_valid_r) begin
        last_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_first_r   <= first;
      s1_emit_r    <= blk_end && band_end;
      s1_row_end_r <= last_blk;
      s1_idx_r     <= bcol_r;
      s1_v_r       <= v;
    end
    if (s1_valid_r) begin
      last_idx_r <= s1_idx_r;
      last_sum_r <= sum;
    end
  end

  ebad_ram #(
    .WIDTH (ebad_pkg::SUM_W),
    .DEPTH (ebad_pkg::MAX_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_idx_r),
    .wdata (sum),
    .re    (accept),
    .raddr (bcol_r),
    .rdata (ram_q)
  );

  // Take the latest write when it hits the same column; the RAM still
  // holds the older value for a write on the read edge
  assign base = (last_valid_r && (last_idx_r == s1_idx_r)) ? last_sum_r
                                                         : ebad_pkg::sum_t'(ram_q);
  assign sum  = s1_first_r ? ebad_pkg::sum_t'(s1_v_r)
                           : base + ebad_pkg::sum_t'(s1_v_r);

  assign q_push          = s1_valid_r && s1_emit_r;
  assign q_entry.sum     = sum;
  assign q_entry.row_end = s1_row_end_r;

endmodule

`default_nettype wire

### src/ebad_fifo.sv
// ============================================================================
// ebad_fifo: short queue of finished block sums
// Decouples the accumulator from the mean divider; exposes its fill level.
// ============================================================================
`default_nettype none

module ebad_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ebad_pkg::blk_entry_t wr_entry,
  input  logic                 pop,
  output ebad_pkg::blk_entry_t rd_entry,
  output logic                 empty,
  output ebad_pkg::qcnt_t      count
);

  ebad_pkg::blk_entry_t slots_r [ebad_pkg::QUEUE_DEPTH];
  ebad_pkg::qptr_t      wr_ptr_r, rd_ptr_r;
  ebad_pkg::qcnt_t      count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + ebad_pkg::qcnt_t'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - ebad_pkg::qcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + ebad_pkg::qptr_t'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + ebad_pkg::qptr_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wr_entry;
    end
  end

  assign rd_entry = slots_r[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign count    = count_r;

endmodule

`default_nettype wire

### src/ebad_back.sv
// ============================================================================
// ebad_back: block mean divider and result register
// Divides sum * 256 by block area, four quotient bits per cycle, truncating
// toward zero, and holds each mean until it is popped.
// ============================================================================
`default_nettype none

module ebad_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  ebad_pkg::blk_entry_t q_entry,
  output logic                 q_pop,
  input  ebad_pkg::nsq_t       area,
  output logic                 empty,
  input  logic                 pop,
  output ebad_pkg::out_item_t  out_data
);

  ebad_pkg::back_state_t state_r, state_nxt;
  ebad_pkg::dcnt_t       cnt_r, cnt_nxt;
  ebad_pkg::dvd_t        dvd_r, dvd_step;
  ebad_pkg::nsq_t        rem_r, rem_step;
  ebad_pkg::trial_t      trial;
  logic                  neg_r, row_end_r;
  ebad_pkg::mag_t        mag;
  ebad_pkg::mean_t       quo;
  logic                  out_valid_r, out_free;
  ebad_pkg::out_item_t   out_r;
  logic                  div_load, div_step, out_load;

  assign out_free = !out_valid_r || pop;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ebad_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = ebad_pkg::BK_RUN;
        end
      end
      ebad_pkg::BK_RUN: begin
        if (cnt_r == ebad_pkg::dcnt_t'(ebad_pkg::DIV_STEPS - 1)) begin
          state_nxt = ebad_pkg::BK_DONE;
        end
      end
      ebad_pkg::BK_DONE: begin
        if (out_free) begin
          state_nxt = ebad_pkg::BK_IDLE;
        end
      end
      default: state_nxt = ebad_pkg::BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    div_load = 1'b0;
    div_step = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ebad_pkg::BK_IDLE: div_load = !q_empty;
      ebad_pkg::BK_RUN:  div_step = 1'b1;
      ebad_pkg::BK_DONE: out_load = out_free;
      default:           ;
    endcase
  end

  assign q_pop = div_load;

  // Magnitude of the signed sum
  assign mag = q_entry.sum[ebad_pkg::SUM_W-1] ? ebad_pkg::mag_t'(~q_entry.sum + 1'b1)
                                              : ebad_pkg::mag_t'(q_entry.sum);

  // Restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    rem_step = rem_r;
    dvd_step = dvd_r;
    trial    = '0;
    for (int i = 0; i < ebad_pkg::DIV_BITS; i++) begin
      trial = {rem_step, dvd_step[ebad_pkg::DVD_W-1]};
      if (trial >= {1'b0, area}) begin
        rem_step = ebad_pkg::nsq_t'(trial - {1'b0, area});
        dvd_step = {dvd_step[ebad_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_step = ebad_pkg::nsq_t'(trial);
        dvd_step = {dvd_step[ebad_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (div_load) begin
      cnt_nxt = '0;
    end else if (div_step) begin
      cnt_nxt = cnt_r + ebad_pkg::dcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ebad_pkg::BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_load || (out_valid_r && !pop);
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      dvd_r     <= {mag, ebad_pkg::FRAC_W'(0)};
      rem_r     <= '0;
      neg_r     <= q_entry.sum[ebad_pkg::SUM_W-1];
      row_end_r <= q_entry.row_end;
    end else if (div_step) begin
      dvd_r <= dvd_step;
      rem_r <= rem_step;
    end
    if (out_load) begin
      out_r.block_mean <= neg_r ? -quo : quo;
      out_r.row_end    <= row_end_r;
    end
  end

  // Only the low quotient bits survive the 24-bit result
  assign quo = ebad_pkg::mean_t'(dvd_r[ebad_pkg::MEAN_W-1:0]);

  assign empty    = !out_valid_r;
  assign out_data = out_r;

endmodule

`default_nettype wire

### src/elevation_box_average_decimator_core.sv
// ============================================================================
// elevation_box_average_decimator_core: N-by-N box average of an elevation grid
// Streams signed 16-bit samples in raster order and emits one 8-fraction-bit
// mean per full block, with a row-end mark on the last block of each row.
// ============================================================================
// Usage: the input side takes one sample per clock while full is low; it
// drops full only when the result queue has room. Each block sum is queued
// (four entries) and divided by N*N in a shared divider that loads the sum,
// runs its division steps and hands the mean off before it takes the next
// sum. On the last row of a band the means arrive one per N samples, so for
// blocks wide enough that each mean is done before the next block closes
// the block runs at one sample per clock; smaller blocks stall the input on
// that row once the queue fills. After any register write, full stays high
// while the row geometry (blocks per row and covered columns) is worked out
// by a bit-serial divider. Samples equal to nodata_value are replaced by
// sea_value; trailing columns that do not fill a block are consumed silently,
// and a partial band is dropped at frame end. Write configuration only while
// no result is pending.
`default_nettype none

module elevation_box_average_decimator_core (
  input  logic                clk,
  input  logic                rst_n,
  // Sample side
  input  logic                push,
  input  ebad_pkg::in_item_t  in_data,
  output logic                full,
  // Result side
  output logic                empty,
  input  logic                pop,
  output ebad_pkg::out_item_t out_data,
  // Configuration writes
  input  logic                cfg_we,
  input  ebad_pkg::cfg_idx_t  cfg_index,
  input  ebad_pkg::cfg_data_t cfg_data
);

  // Configuration registers, raw as written
  ebad_pkg::width_t  grid_width_r;
  ebad_pkg::bsize_t  block_size_r;
  ebad_pkg::sample_t nodata_r;
  ebad_pkg::sample_t sea_r;
  logic              cfg_we_d_r;   // kick off the geometry pass
  ebad_pkg::nsq_t    area_r;       // N * N for the divider

  ebad_pkg::cfg_t       cfg_eff;
  ebad_pkg::geo_t       geo;
  logic                 accept;
  logic                 q_push, q_pop, q_empty;
  ebad_pkg::blk_entry_t q_wr, q_rd;
  ebad_pkg::qcnt_t      q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= ebad_pkg::width_t'(ebad_pkg::GRID_WIDTH_RST);
      block_size_r <= ebad_pkg::bsize_t'(ebad_pkg::BLOCK_SIZE_RST);
      nodata_r     <= '0;
      sea_r        <= '0;
      cfg_we_d_r   <= 1'b0;
    end else begin
      cfg_we_d_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          ebad_pkg::CFG_GRID_WIDTH: grid_width_r <= cfg_data[ebad_pkg::GW_W-1:0];
          ebad_pkg::CFG_BLOCK_SIZE: block_size_r <= cfg_data[ebad_pkg::BS_W-1:0];
          ebad_pkg::CFG_NODATA:     nodata_r     <= ebad_pkg::sample_t'(cfg_data);
          ebad_pkg::CFG_SEA:        sea_r        <= ebad_pkg::sample_t'(cfg_data);
          default:                  ;
        endcase
      end
    end
  end

  // Clamp: zero acts as one, oversize acts as the storage limit
  always_comb begin
    cfg_eff.width  = grid_width_r;
    cfg_eff.block  = block_size_r;
    cfg_eff.nodata = nodata_r;
    cfg_eff.sea    = sea_r;
    if (grid_width_r == '0) begin
      cfg_eff.width = ebad_pkg::width_t'(1);
    end else if (int'(grid_width_r) > ebad_pkg::MAX_WIDTH) begin
      cfg_eff.width = ebad_pkg::width_t'(ebad_pkg::MAX_WIDTH);
    end
    if (block_size_r == '0) begin
      cfg_eff.block = ebad_pkg::bsize_t'(1);
    end else if (int'(block_size_r) > ebad_pkg::MAX_BLOCK) begin
      cfg_eff.block = ebad_pkg::bsize_t'(ebad_pkg::MAX_BLOCK);
    end
  end

  always_ff @(posedge clk) begin
    area_r <= ebad_pkg::nsq_t'(cfg_eff.block) * ebad_pkg::nsq_t'(cfg_eff.block);
  end

  // Hold input while geometry is stale or the queue may not absorb two more
  assign full   = geo.busy || cfg_we_d_r
               || (q_count > ebad_pkg::qcnt_t'(ebad_pkg::QUEUE_DEPTH - 2));
  assign accept = push && !full;

  ebad_geom u_geom (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_we_d_r),
    .cfg   (cfg_eff),
    .geo   (geo)
  );

  ebad_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .cfg     (cfg_eff),
    .geo     (geo),
    .q_push  (q_push),
    .q_entry (q_wr)
  );

  ebad_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr),
    .pop      (q_pop),
    .rd_entry (q_rd),
    .empty    (q_empty),
    .count    (q_count)
  );

  ebad_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_entry  (q_rd),
    .q_pop    (q_pop),
    .area     (area_r),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

### bench/elevation_box_average_decimator_core_test.sv
// ============================================================================
// elevation_box_average_decimator_core_test: box-average decimator regression
// Streams raster samples with frame ends through the core under a range of
// grid widths, block sides and no-data settings. A cycle-free predictor
// works out every block mean and row-end mark, and each result popped
// from the core is checked against the oldest outstanding prediction.
// ============================================================================
`default_nettype none

module elevation_box_average_decimator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 700;   // random samples before the random part may stop
  localparam int RESULT_GOAL   = 48;    // random part also runs until this many means
  localparam int SETTLE_CYCLES = 64;    // geometry reload plus divider, with margin
  localparam int LONG_HOLD     = 400;   // result stall that backs the core up
  localparam int FRAME_CAP     = 400;   // longest random frame, in samples
  localparam int REPORT_LIMIT  = 100;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs (all known from time zero)
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  ebad_pkg::in_item_t   in_data = '0;
  logic                 full;
  logic                 empty;
  logic                 pop = 1'b0;
  ebad_pkg::out_item_t  out_data;
  logic                 cfg_we = 1'b0;
  ebad_pkg::cfg_idx_t   cfg_index = ebad_pkg::CFG_GRID_WIDTH;
  ebad_pkg::cfg_data_t  cfg_data = '0;

  always #6 clk = ~clk;

  elevation_box_average_decimator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: register copies (raw, as written) and the band counters
  // --------------------------------------------------------------------------
  ebad_pkg::width_t  grid_width_reg = ebad_pkg::width_t'(ebad_pkg::GRID_WIDTH_RST);
  ebad_pkg::bsize_t  block_size_reg = ebad_pkg::bsize_t'(ebad_pkg::BLOCK_SIZE_RST);
  ebad_pkg::sample_t nodata_reg = '0;
  ebad_pkg::sample_t sea_reg = '0;

  longint      band_sums [ebad_pkg::MAX_WIDTH] = '{default: 0};
  int unsigned raster_col = 0;   // column within the raster row
  int unsigned band_row = 0;     // row within the current band
  int unsigned block_pos = 0;    // column within the current block
  int unsigned block_idx = 0;    // block column, also the accumulator index

  ebad_pkg::out_item_t mean_fifo [$];    // block means still owed by the core

  // Bookkeeping
  int                  errors = 0;
  int                  items_sent = 0;
  int                  means_owed = 0;
  int                  means_seen = 0;
  int                  settings_used = 0;
  bit                  gaps_on = 1'b1;   // random idling on both sides
  int                  holds_wanted = 0; // long result stalls requested by the tests
  int                  holds_done = 0;
  int                  hold_left = 0;
  int                  stall_left = 0;
  ebad_pkg::out_item_t want;

  // Clamp the raw registers the way the core reads them.
  function automatic int unsigned eff_width();
    if (grid_width_reg == 0) return 1;
    if (grid_width_reg > ebad_pkg::MAX_WIDTH) return ebad_pkg::MAX_WIDTH;
    return grid_width_reg;
  endfunction

  function automatic int unsigned eff_block();
    if (block_size_reg == 0) return 1;
    if (block_size_reg > ebad_pkg::MAX_BLOCK) return ebad_pkg::MAX_BLOCK;
    return block_size_reg;
  endfunction

  // Advance the band counters by one sample; return 1 when a block closes
  // on the last row of its band, with the mean and row-end mark in mean_out.
  function automatic bit decimate_sample(input ebad_pkg::in_item_t item,
                                         output ebad_pkg::out_item_t mean_out);
    int unsigned w;
    int unsigned n;
    int unsigned nblk;
    longint      v;
    longint      sum;
    bit          made;
    w = eff_width();
    n = eff_block();
    nblk = w / n;
    made = 1'b0;
    mean_out = '0;
    v = (item.sample == nodata_reg) ? sea_reg : item.sample;

    // Columns past the last full block are consumed silently.
    if (raster_col < nblk * n) begin
      if (band_row == 0 && block_pos == 0) sum = v;
      else sum = band_sums[block_idx] + v;
      band_sums[block_idx] = sum;
      if (block_pos + 1 >= n) begin
        if (band_row + 1 >= n) begin
          // Signed division truncates toward zero.
          mean_out.block_mean = ebad_pkg::mean_t'((sum * 256) / longint'(n * n));
          mean_out.row_end = (block_idx + 1 >= nblk);
          made = 1'b1;
        end
        block_pos = 0;
        block_idx = (block_idx + 1) % ebad_pkg::MAX_WIDTH;
      end else begin
        block_pos++;
      end
    end

    if (raster_col + 1 >= w) begin
      raster_col = 0;
      block_pos = 0;
      block_idx = 0;
      band_row = (band_row + 1 >= n) ? 0 : band_row + 1;
    end else begin
      raster_col++;
    end

    // Frame end drops any partly summed band.
    if (item.frame_end) begin
      raster_col = 0;
      band_row = 0;
      block_pos = 0;
      block_idx = 0;
    end
    return made;
  endfunction

  // --------------------------------------------------------------------------
  // Shared driver pieces
  // --------------------------------------------------------------------------

  // Offer one sample and hold it until the core takes it, then predict.
  task automatic send_sample(input ebad_pkg::sample_t value, input logic last);
    ebad_pkg::in_item_t  item;
    ebad_pkg::out_item_t mean;
    item.sample = value;
    item.frame_end = last;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    push <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (full) @(posedge clk);
    // The transfer happened at this edge.
    if (decimate_sample(item, mean)) begin
      mean_fifo.push_back(mean);
      means_owed++;
    end
    items_sent++;
  endtask

  // Stop offering, wait for every owed mean, then let the core settle.
  task automatic drain_results();
    push <= 1'b0;
    while (mean_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back; the core must be idle.
  task automatic configure(input int unsigned width, input int unsigned block,
                           input ebad_pkg::sample_t nodata,
                           input ebad_pkg::sample_t sea);
    cfg_we <= 1'b1;
    cfg_index <= ebad_pkg::CFG_GRID_WIDTH;
    cfg_data <= ebad_pkg::cfg_data_t'(width);
    @(posedge clk);
    cfg_index <= ebad_pkg::CFG_BLOCK_SIZE;
    cfg_data <= ebad_pkg::cfg_data_t'(block);
    @(posedge clk);
    cfg_index <= ebad_pkg::CFG_NODATA;
    cfg_data <= nodata;
    @(posedge clk);
    cfg_index <= ebad_pkg::CFG_SEA;
    cfg_data <= sea;
    @(posedge clk);
    cfg_we <= 1'b0;
    grid_width_reg = width[ebad_pkg::GW_W-1:0];
    block_size_reg = block[ebad_pkg::BS_W-1:0];
    nodata_reg = nodata;
    sea_reg = sea;
    settings_used++;
  endtask

  // Mostly random content, with extremes and the no-data marker mixed in.
  function automatic ebad_pkg::sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return nodata_reg;
      1:       return ebad_pkg::sample_t'(16'h7fff);
      2:       return ebad_pkg::sample_t'(16'h8000);
      default: return ebad_pkg::sample_t'($urandom());
    endcase
  endfunction

  // Send one frame of whole rows (capped), with rare stray frame ends.
  task automatic send_frame(input int unsigned rows);
    int unsigned total;
    int unsigned k;
    logic        last;
    total = eff_width() * rows;
    if (total > FRAME_CAP) total = FRAME_CAP;
    for (k = 0; k < total; k++) begin
      last = (k == total - 1);
      if (!last && $urandom_range(0, 299) == 0) last = 1'b1;
      send_sample(pick_sample(), last);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: pop with random stalls, long hold-offs on request, and check
  // each transfer against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        means_seen++;
        if (mean_fifo.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t ns: unexpected mean: expected none, actual mean %0d row_end %b",
                     $time, out_data.block_mean, out_data.row_end);
        end else begin
          want = mean_fifo.pop_front();
          if (out_data.block_mean !== want.block_mean) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("%0t ns: block_mean mismatch: expected %0d, actual %0d",
                       $time, want.block_mean, out_data.block_mean);
          end
          if (out_data.row_end !== want.row_end) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("%0t ns: row_end mismatch: expected %b, actual %b",
                       $time, want.row_end, out_data.row_end);
          end
        end
      end

      // Start a requested long hold-off; it is counted here, not by the sender.
      if (holds_done < holds_wanted) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: full-width rows, single-sample blocks, zero as no-data.
  task automatic test_power_on_defaults();
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sd32767, 1'b1);
    drain_results();
  endtask

  // Largest and smallest samples, and a no-data hit replaced by the low extreme.
  task automatic test_field_extremes();
    configure(4, 1, 16'sd1234, ebad_pkg::sample_t'(16'h8000));
    send_sample(16'sd32767, 1'b0);
    send_sample(ebad_pkg::sample_t'(16'h8000), 1'b0);
    send_sample(16'sd1234, 1'b0);
    send_sample(16'sd0, 1'b1);
    drain_results();
  endtask

  // Out-of-range registers: zero width with an oversize block (block wider
  // than the row, so nothing comes out), then oversize width with zero block.
  task automatic test_register_extremes();
    configure(0, 31, ebad_pkg::sample_t'(16'h8000), 16'sd32767);
    send_sample(ebad_pkg::sample_t'(16'h8000), 1'b0);
    send_sample(16'sd5, 1'b1);
    drain_results();
    configure(8191, 0, 16'sd32767, ebad_pkg::sample_t'(16'h8000));
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd100, 1'b1);
    drain_results();
  endtask

  // One 3x3 block with a trailing column, a negative sum that truncates
  // toward zero, a no-data hit, then a partial band cut off by frame end.
  task automatic test_band_geometry();
    configure(4, 3, 16'sd100, 16'sd0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd9999, 1'b0);    // trailing column
    repeat (2) begin
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(-16'sd9999, 1'b0);
    end
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd6, 1'b1);       // drops the half band
    drain_results();
  endtask

  // Rewrite registers between the two rows of a band: narrower rows and a
  // new no-data pair, with the counters left running.
  task automatic test_midframe_change();
    configure(4, 2, ebad_pkg::sample_t'(16'h8000), 16'sd32767);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd4, 1'b0);
    drain_results();
    configure(2, 2, 16'sd3, -16'sd3);
    send_sample(16'sd3, 1'b0);
    send_sample(ebad_pkg::sample_t'(16'h8000), 1'b1);
    drain_results();
  endtask

  // Hold results off for a long stretch while samples keep coming.
  task automatic test_result_backpressure();
    int k;
    configure(2, 1, 16'sd0, 16'sd7);
    holds_wanted++;
    for (k = 0; k < 40; k++) send_sample(pick_sample(), k == 39);
    drain_results();
  endtask

  // Random settings, each followed by a few frames of whole bands, some with a partial band at the end.
  task automatic test_random_frames();
    int                start_items;
    int                start_means;
    int unsigned       width;
    int unsigned       block;
    int                frames;
    ebad_pkg::sample_t nodata;
    start_items = items_sent;
    start_means = means_owed;
    while (items_sent - start_items < RANDOM_ITEMS ||
           means_owed - start_means < RESULT_GOAL) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: width = $urandom_range(1, 40);
        7, 8:                width = $urandom_range(41, 300);
        default: begin
          case ($urandom_range(0, 3))
            0:       width = 0;
            1:       width = ebad_pkg::MAX_WIDTH;
            2:       width = 8191;
            default: width = $urandom_range(ebad_pkg::MAX_WIDTH + 1, 8191);
          endcase
        end
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: block = $urandom_range(1, 4);
        6, 7, 8:          block = $urandom_range(5, ebad_pkg::MAX_BLOCK);
        default:          block = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
      endcase
      nodata = ($urandom_range(0, 3) == 0) ? ebad_pkg::sample_t'(16'h8000)
                                           : ebad_pkg::sample_t'($urandom());
      configure(width, block, nodata, ebad_pkg::sample_t'($urandom()));
      gaps_on = ($urandom_range(0, 4) != 0);
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        // Whole bands, sometimes with a partial band left for frame end.
        send_frame(eff_block() * $urandom_range(1, 3) +
                   (($urandom_range(0, 3) == 0) ? $urandom_range(1, eff_block()) : 0));
      end
      drain_results();
    end
  endtask

  // Closing stretch with no idling on either side: 4x4 blocks at full rate.
  task automatic test_full_rate();
    configure(8, 4, 16'sd0, -16'sd100);
    repeat (2) send_frame(8);
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_power_on_defaults();
    test_field_extremes();
    test_register_extremes();
    test_band_geometry();
    test_midframe_change();
    test_result_backpressure();
    test_random_frames();
    gaps_on = 1'b0;
    test_full_rate();
    $display("Covered %0d samples over %0d register settings; %0d block means checked,",
             items_sent, settings_used, means_seen);
    $display("including clamped widths and block sides, partial bands and a long result stall.");
    if (errors == 0 && mean_fifo.size() == 0) begin
      $display("elevation_box_average_decimator_core regression: pass");
    end else begin
      $display("elevation_box_average_decimator_core regression: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #6_000_000;
    $display("Timed out with %0d means still owed", mean_fifo.size());
    $display("elevation_box_average_decimator_core regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
src/ebad_pkg.sv
src/ebad_ram.sv
src/ebad_geom.sv
src/ebad_front.sv
src/ebad_fifo.sv
src/ebad_back.sv
src/elevation_box_average_decimator_core.sv
bench/elevation_box_average_decimator_core_test.sv
